/* rtl/core/ple_pkg.sv */
// Package for the piecewise-linear evaluator: sizes, codes and item types.
// Used by every module of the block but ple_ram; depends on nothing.
package ple_pkg;

   localparam int NUM_CURVES   = 16;
   localparam int MAX_SEGMENTS = 8;

   localparam int DATA_W    = 32;
   localparam int Q_FRAC    = 16;
   localparam int BP_STRIDE = MAX_SEGMENTS + 1;
   localparam int BP_DEPTH  = NUM_CURVES * BP_STRIDE;
   localparam int SEG_DEPTH = NUM_CURVES * MAX_SEGMENTS;
   localparam int BP_AW     = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;
   localparam int SEG_AW    = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
   localparam int CURVE_AW  = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
   localparam int CNT_W     = $clog2(MAX_SEGMENTS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [DATA_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] RES_MIN = 32'sh8000_0000;

   localparam logic [2:0] MODE_LOAD_BP    = 3'd0;
   localparam logic [2:0] MODE_LOAD_SLOPE = 3'd1;
   localparam logic [2:0] MODE_LOAD_BASE  = 3'd2;
   localparam logic [2:0] MODE_LOAD_COUNT = 3'd3;
   localparam logic [2:0] MODE_EVAL       = 3'd4;

   localparam logic [1:0] STATUS_BELOW   = 2'd0;
   localparam logic [1:0] STATUS_SEGMENT = 2'd1;
   localparam logic [1:0] STATUS_BEYOND  = 2'd2;
   localparam logic [1:0] STATUS_LOADED  = 2'd3;

   typedef struct packed {
      logic [2:0]               mode;
      logic [3:0]               curve;
      logic [3:0]               index;
      logic signed [DATA_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result;
      logic [1:0]               status;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_WR_BP,
      CMD_WR_SLOPE,
      CMD_WR_BASE,
      CMD_WR_COUNT,
      CMD_EVAL,
      CMD_LOAD_NOP,
      CMD_EVAL_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [BP_AW-1:0]         bp_addr;
      logic [SEG_AW-1:0]        seg_addr;
      logic [CURVE_AW-1:0]      curve;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] operand;
   } cmd_type;

endpackage

/* rtl/core/ple_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
module ple_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ple_front.sv */
// Front end: decodes each input item into a command and holds it in a short queue.
// Depends on ple_pkg.
module ple_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  ple_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output ple_pkg::cmd_type cmd_data
);
   import ple_pkg::*;

   cmd_type           cmd_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic        accept;
   logic        curve_ok;
   logic [31:0] curve_ext;
   logic [3:0]  bp_idx;
   logic [3:0]  seg_idx;
   logic [31:0] bp_lin;
   logic [31:0] seg_lin;
   cmd_type     decoded;

   assign accept    = req_push && !req_full;
   assign curve_ext = {28'd0, req_data.curve};
   assign curve_ok  = curve_ext < 32'(NUM_CURVES);
   assign bp_idx    = (req_data.mode == MODE_EVAL) ? 4'd0 : req_data.index;
   assign seg_idx   = (req_data.mode == MODE_EVAL) ? 4'd0 : req_data.index;
   assign bp_lin    = curve_ext * 32'(BP_STRIDE) + {28'd0, bp_idx};
   assign seg_lin   = curve_ext * 32'(MAX_SEGMENTS) + {28'd0, seg_idx};

   always_comb begin
      decoded.bp_addr  = bp_lin[BP_AW-1:0];
      decoded.seg_addr = seg_lin[SEG_AW-1:0];
      decoded.curve    = curve_ext[CURVE_AW-1:0];
      decoded.operand  = req_data.operand;
      if (req_data.operand[DATA_W-1]) begin
         decoded.count = '0;
      end else if (req_data.operand > 32'(MAX_SEGMENTS)) begin
         decoded.count = CNT_W'(MAX_SEGMENTS);
      end else begin
         decoded.count = req_data.operand[CNT_W-1:0];
      end
      decoded.kind = CMD_LOAD_NOP;
      case (req_data.mode)
         MODE_LOAD_BP: begin
            if (curve_ok && ({28'd0, req_data.index} <= 32'(MAX_SEGMENTS))) begin
               decoded.kind = CMD_WR_BP;
            end
         end
         MODE_LOAD_SLOPE: begin
            if (curve_ok && ({28'd0, req_data.index} < 32'(MAX_SEGMENTS))) begin
               decoded.kind = CMD_WR_SLOPE;
            end
         end
         MODE_LOAD_BASE: begin
            if (curve_ok && ({28'd0, req_data.index} < 32'(MAX_SEGMENTS))) begin
               decoded.kind = CMD_WR_BASE;
            end
         end
         MODE_LOAD_COUNT: begin
            if (curve_ok) begin
               decoded.kind = CMD_WR_COUNT;
            end
         end
         MODE_EVAL: begin
            decoded.kind = curve_ok ? CMD_EVAL : CMD_EVAL_NOP;
         end
         default: begin
            decoded.kind = CMD_LOAD_NOP;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (cmd_take && cmd_valid) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (accept && !(cmd_take && cmd_valid)) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!accept && (cmd_take && cmd_valid)) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff[wr_ptr_ff] <= decoded;
      end
   end

   assign req_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = cmd_ff[rd_ptr_ff];

endmodule

/* rtl/core/ple_rspq.sv */
// Result queue: a short queue of finished result items in front of the rsp_ ports.
// Depends on ple_pkg.
module ple_rspq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             ready,
   input  ple_pkg::rsp_type push_data,
   output logic             empty,
   input  logic             pop,
   output ple_pkg::rsp_type head_data
);
   import ple_pkg::*;

   rsp_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign ready   = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && ready;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];

endmodule

/* rtl/core/ple_back.sv */
// Back end: curve storage, breakpoint scan and the multiply-add of one command at a time.
// Depends on ple_pkg and ple_ram.
module ple_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  ple_pkg::cmd_type cmd_data,
   output logic             out_push,
   input  logic             out_ready,
   output ple_pkg::rsp_type out_data
);
   import ple_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_SUM
   } state_type;

   localparam logic signed [49:0] SUM_MAX = 50'(RES_MAX);
   localparam logic signed [49:0] SUM_MIN = 50'(RES_MIN);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         k_ff, k_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [DATA_W-1:0] x_ff, x_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic [BP_AW-1:0]         bp_base_ff, bp_base_in;
   logic [SEG_AW-1:0]        seg_base_ff, seg_base_in;
   logic signed [DATA_W-1:0] slope_ff, slope_in;
   logic signed [DATA_W-1:0] base_ff, base_in;
   logic signed [DATA_W:0]   diff_ff, diff_in;
   logic signed [64:0]       prod_ff, prod_in;
   logic                     out_valid_ff, out_valid_in;
   rsp_type                  out_ff, out_in;

   logic [CNT_W-1:0] counts_ff [NUM_CURVES];
   logic             cnt_we;

   logic                     bp_we, bp_re;
   logic [BP_AW-1:0]         bp_wa, bp_ra;
   logic [DATA_W-1:0]        bp_rdata;
   logic                     slope_we, base_we, seg_re;
   logic [SEG_AW-1:0]        seg_ra;
   logic [DATA_W-1:0]        slope_rdata, base_rdata;
   logic signed [DATA_W-1:0] bp_val;
   logic                     can_start;

   logic signed [64:0] rnd_full;
   logic signed [49:0] sum_v;

   assign bp_val    = $signed(bp_rdata);
   assign can_start = !out_valid_ff || out_ready;
   assign rnd_full  = (prod_ff + 65'sd32768) >>> Q_FRAC;
   assign sum_v     = {rnd_full[48], rnd_full[48:0]} + {{18{base_ff[DATA_W-1]}}, base_ff};

   ple_ram #(.WIDTH(DATA_W), .DEPTH(BP_DEPTH), .ADDR_W(BP_AW)) u_bp_ram (
      .clock   (clock),
      .wr_en   (bp_we),
      .wr_addr (bp_wa),
      .wr_data (cmd_data.operand),
      .rd_en   (bp_re),
      .rd_addr (bp_ra),
      .rd_data (bp_rdata)
   );

   ple_ram #(.WIDTH(DATA_W), .DEPTH(SEG_DEPTH), .ADDR_W(SEG_AW)) u_slope_ram (
      .clock   (clock),
      .wr_en   (slope_we),
      .wr_addr (cmd_data.seg_addr),
      .wr_data (cmd_data.operand),
      .rd_en   (seg_re),
      .rd_addr (seg_ra),
      .rd_data (slope_rdata)
   );

   ple_ram #(.WIDTH(DATA_W), .DEPTH(SEG_DEPTH), .ADDR_W(SEG_AW)) u_base_ram (
      .clock   (clock),
      .wr_en   (base_we),
      .wr_addr (cmd_data.seg_addr),
      .wr_data (cmd_data.operand),
      .rd_en   (seg_re),
      .rd_addr (seg_ra),
      .rd_data (base_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      prev_in      = prev_ff;
      bp_base_in   = bp_base_ff;
      seg_base_in  = seg_base_ff;
      slope_in     = slope_ff;
      base_in      = base_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      cmd_take     = 1'b0;
      cnt_we       = 1'b0;
      bp_we        = 1'b0;
      bp_wa        = cmd_data.bp_addr;
      bp_re        = 1'b0;
      bp_ra        = bp_base_ff + BP_AW'(k_ff + CNT_W'(1));
      slope_we     = 1'b0;
      base_we      = 1'b0;
      seg_re       = 1'b0;
      seg_ra       = seg_base_ff + SEG_AW'(k_ff);
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && can_start) begin
               cmd_take      = 1'b1;
               out_in.result = '0;
               out_in.status = STATUS_LOADED;
               case (cmd_data.kind)
                  CMD_WR_BP: begin
                     bp_we        = 1'b1;
                     out_valid_in = 1'b1;
                  end
                  CMD_WR_SLOPE: begin
                     slope_we     = 1'b1;
                     out_valid_in = 1'b1;
                  end
                  CMD_WR_BASE: begin
                     base_we      = 1'b1;
                     out_valid_in = 1'b1;
                  end
                  CMD_WR_COUNT: begin
                     cnt_we       = 1'b1;
                     out_valid_in = 1'b1;
                  end
                  CMD_EVAL_NOP: begin
                     out_in.status = STATUS_BELOW;
                     out_valid_in  = 1'b1;
                  end
                  CMD_EVAL: begin
                     // The first breakpoint is read now and checked in the scan state.
                     bp_re       = 1'b1;
                     bp_ra       = cmd_data.bp_addr;
                     bp_base_in  = cmd_data.bp_addr;
                     seg_base_in = cmd_data.seg_addr;
                     x_in        = cmd_data.operand;
                     cnt_in      = counts_ff[cmd_data.curve];
                     k_in        = '0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // bp_val holds breakpoint k; slope and base of segment k-1 arrived with it.
            if (k_ff == '0) begin
               if (x_ff < bp_val) begin
                  out_in.result = '0;
                  out_in.status = STATUS_BELOW;
                  out_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end else if (cnt_ff == '0) begin
                  out_in.result = RES_MAX;
                  out_in.status = STATUS_BEYOND;
                  out_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  prev_in = bp_val;
                  bp_re   = 1'b1;
                  seg_re  = 1'b1;
                  k_in    = k_ff + CNT_W'(1);
               end
            end else if ((prev_ff <= x_ff) && (x_ff < bp_val)) begin
               slope_in = $signed(slope_rdata);
               base_in  = $signed(base_rdata);
               diff_in  = {x_ff[DATA_W-1], x_ff} - {prev_ff[DATA_W-1], prev_ff};
               state_in = ST_MUL;
            end else if (k_ff == cnt_ff) begin
               out_in.result = RES_MAX;
               out_in.status = STATUS_BEYOND;
               out_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               prev_in = bp_val;
               bp_re   = 1'b1;
               seg_re  = 1'b1;
               k_in    = k_ff + CNT_W'(1);
            end
         end
         ST_MUL: begin
            prod_in  = slope_ff * diff_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum_v > SUM_MAX) begin
               out_in.result = RES_MAX;
            end else if (sum_v < SUM_MIN) begin
               out_in.result = RES_MIN;
            end else begin
               out_in.result = sum_v[DATA_W-1:0];
            end
            out_in.status = STATUS_SEGMENT;
            out_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      x_ff        <= x_in;
      prev_ff     <= prev_in;
      bp_base_ff  <= bp_base_in;
      seg_base_ff <= seg_base_in;
      slope_ff    <= slope_in;
      base_ff     <= base_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      out_ff      <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CURVES; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         counts_ff[cmd_data.curve] <= cmd_data.count;
      end
   end

   assign out_push = out_valid_ff;
   assign out_data = out_ff;

endmodule

/* rtl/core/piecewise_linear_evaluator.sv */
// Top level of the piecewise-linear curve evaluator (signed Q16.16).
// Depends on ple_pkg, ple_front, ple_back and ple_rspq.
//
//   Channel   Ports                          Moves
//   request   req_push, req_full, req_data   load or evaluate item
//   response  rsp_empty, rsp_pop, rsp_data   result and status, one per item
//
// Load items and other items without a scan finish in the idle state of the back end.
// An evaluate item reads the first breakpoint in the idle state, checks it in the scan
// state, then scans one breakpoint after another (up to the curve's segment count), and
// then multiplies in the multiply state and does the rounding add in the sum state; the
// breakpoint RAM read port sets the scan rate. Reset clears the queues and all segment counts.
// Two-entry queues on both sides let input and output stall independently.
module piecewise_linear_evaluator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  ple_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ple_pkg::rsp_type rsp_data
);
   import ple_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_data;
   logic    out_push;
   logic    out_ready;
   rsp_type out_data;

   ple_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data)
   );

   ple_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data),
      .out_push  (out_push),
      .out_ready (out_ready),
      .out_data  (out_data)
   );

   ple_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .ready     (out_ready),
      .push_data (out_data),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head_data (rsp_data)
   );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the piecewise-linear curve evaluator.
// Drives load and evaluate items through the request queue and checks every response
// against a Q16.16 curve predictor held in a small scoreboard class. Depends on ple_pkg.
`timescale 1ns / 1ps

module testbench;
   import ple_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 7;
   localparam int ITEM_TARGET  = 1350;
   localparam int LONG_HOLD    = 400;
   localparam int STALL_LIMIT  = 3000;
   localparam int SETTLE       = 4 * (MAX_SEGMENTS + 5);

   // Curve store and response predictor, plus the queue of responses still owed.
   class curve_scoreboard;
      logic signed [DATA_W-1:0] knot       [NUM_CURVES][BP_STRIDE];
      logic signed [DATA_W-1:0] slope_tab  [NUM_CURVES][MAX_SEGMENTS];
      logic signed [DATA_W-1:0] offset_tab [NUM_CURVES][MAX_SEGMENTS];
      int seg_count [NUM_CURVES];
      bit knot_set   [NUM_CURVES][BP_STRIDE];
      bit slope_set  [NUM_CURVES][MAX_SEGMENTS];
      bit offset_set [NUM_CURVES][MAX_SEGMENTS];
      rsp_type awaited [$];
      int failures;

      function rsp_type curve_response(req_type r);
         rsp_type resp;
         longint x, diff, prod, acc;
         int i;
         bit found;
         resp.result = '0;
         resp.status = STATUS_LOADED;
         x = r.operand;
         case (r.mode)
            MODE_LOAD_BP: begin
               if (r.index <= MAX_SEGMENTS) begin
                  knot[r.curve][r.index] = r.operand;
                  knot_set[r.curve][r.index] = 1'b1;
               end
            end
            MODE_LOAD_SLOPE: begin
               if (r.index < MAX_SEGMENTS) begin
                  slope_tab[r.curve][r.index] = r.operand;
                  slope_set[r.curve][r.index] = 1'b1;
               end
            end
            MODE_LOAD_BASE: begin
               if (r.index < MAX_SEGMENTS) begin
                  offset_tab[r.curve][r.index] = r.operand;
                  offset_set[r.curve][r.index] = 1'b1;
               end
            end
            MODE_LOAD_COUNT: begin
               if (x < 0)
                  seg_count[r.curve] = 0;
               else if (x > MAX_SEGMENTS)
                  seg_count[r.curve] = MAX_SEGMENTS;
               else
                  seg_count[r.curve] = int'(x);
            end
            MODE_EVAL: begin
               resp.status = STATUS_BELOW;
               if (x >= knot[r.curve][0]) begin
                  resp.status = STATUS_BEYOND;
                  resp.result = RES_MAX;
                  found = 1'b0;
                  // The first segment that holds x wins, even if later ones overlap it.
                  for (i = 0; i < seg_count[r.curve] && !found; i++) begin
                     if (knot[r.curve][i] <= x && x < knot[r.curve][i+1]) begin
                        diff = x - knot[r.curve][i];
                        prod = slope_tab[r.curve][i] * diff;
                        acc = ((prod + (longint'(1) <<< (Q_FRAC - 1))) >>> Q_FRAC)
                              + offset_tab[r.curve][i];
                        if (acc > RES_MAX) acc = RES_MAX;
                        if (acc < RES_MIN) acc = RES_MIN;
                        resp.result = acc[DATA_W-1:0];
                        resp.status = STATUS_SEGMENT;
                        found = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
         return resp;
      endfunction

      // True when an evaluate on this curve touches only entries that have been loaded.
      function bit curve_ready(int c);
         for (int i = 0; i <= seg_count[c]; i++)
            if (!knot_set[c][i]) return 1'b0;
         for (int i = 0; i < seg_count[c]; i++)
            if (!slope_set[c][i] || !offset_set[c][i]) return 1'b0;
         return 1'b1;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(req_type r);
         awaited.insert(awaited.size(), curve_response(r));
      endfunction

      // Only the first hundred mismatches are printed to keep the log readable.
      task report(string what);
         if (failures < 100) $display("ERROR: %s", what);
         failures++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result %h status %0d", got.result, got.status));
            return;
         end
         want = awaited.pop_front();
         if (got.result !== want.result)
            report($sformatf("result %h, expected %h", got.result, want.result));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   curve_scoreboard sb = new;
   bit hold_request;
   int useful_items;
   int items_offered;
   int idle_cycles;

   piecewise_linear_evaluator uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Mostly short gaps, a few long ones, and every fourth stretch of 80 with none at all.
   function automatic int pick_gap(int seq_no);
      int roll;
      if ((seq_no / 80) % 4 == 1) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_W-1:0] pick_coef();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      if (roll < 7) return $urandom;
      if (roll == 7) return RES_MAX;
      if (roll == 8) return RES_MIN;
      return '0;
   endfunction

   // x values cluster on and around the breakpoints and inside the loaded span.
   function automatic logic [DATA_W-1:0] pick_x(int c);
      int n, i, roll;
      longint lo, hi, span, x;
      n = sb.seg_count[c];
      i = $urandom_range(0, n);
      roll = $urandom_range(0, 9);
      if (roll < 2) return sb.knot[c][i];
      if (roll < 4) return sb.knot[c][i] + $urandom_range(0, 2) - 1;
      lo = sb.knot[c][0];
      hi = sb.knot[c][n];
      if (roll < 7 && hi > lo) begin
         span = hi - lo;
         x = lo + longint'({$urandom, $urandom} % span);
         return x[DATA_W-1:0];
      end
      if (roll == 7) return $urandom_range(0, 1) ? RES_MAX : RES_MIN;
      return $urandom;
   endfunction

   task automatic send_item(input logic [2:0] mode, input int curve, input int index,
                            input logic [DATA_W-1:0] operand, input bit counted);
      req_type item;
      int gap;
      item.mode    = mode;
      item.curve   = 4'(curve);
      item.index   = 4'(index);
      item.operand = operand;
      gap = pick_gap(items_offered);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      sb.note_request(item);
      items_offered++;
      if (counted) useful_items++;
   endtask

   task automatic wait_for_results();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Loads a whole curve, or only its first few items when the sequence is cut short.
   task automatic load_curve(input int c, input int limit);
      int knots [$];
      req_type seq [$];
      req_type item;
      int style, i;
      style = $urandom_range(0, 3);
      for (i = 0; i < BP_STRIDE; i++) begin
         case (style)
            1: knots.insert(i, i == 0 ? $urandom_range(0, 32'h0100_0000) - 32'h0080_0000
                                      : knots[i-1] + $urandom_range(1, 32'h0004_0000));
            3: knots.insert(i, $urandom_range(0, 6) << Q_FRAC);
            default: knots.insert(i, $urandom);
         endcase
      end
      // Unsorted knots are kept for style two, and style three gives empty segments.
      if (style != 2) knots.sort();
      for (i = 0; i < BP_STRIDE; i++) begin
         item = {MODE_LOAD_BP, 4'(c), 4'(i), DATA_W'(knots[i])};
         seq.insert(seq.size(), item);
      end
      for (i = 0; i < MAX_SEGMENTS; i++) begin
         item = {MODE_LOAD_SLOPE, 4'(c), 4'(i), pick_coef()};
         seq.insert(seq.size(), item);
      end
      for (i = 0; i < MAX_SEGMENTS; i++) begin
         item = {MODE_LOAD_BASE, 4'(c), 4'(i), pick_coef()};
         seq.insert(seq.size(), item);
      end
      item = {MODE_LOAD_COUNT, 4'(c), 4'(0),
              ($urandom_range(0, 9) == 0) ? DATA_W'($urandom)
                                          : DATA_W'($urandom_range(0, MAX_SEGMENTS))};
      seq.insert(seq.size(), item);
      for (i = 0; i < seq.size() && i < limit; i++)
         send_item(seq[i].mode, seq[i].curve, seq[i].index, seq[i].operand, 1'b1);
   endtask

   task automatic eval_burst();
      int c, start, k;
      c = -1;
      start = $urandom_range(0, NUM_CURVES - 1);
      for (k = 0; k < NUM_CURVES && c < 0; k++)
         if (sb.curve_ready((start + k) % NUM_CURVES)) c = (start + k) % NUM_CURVES;
      if (c < 0) begin
         load_curve(start, 2 * BP_STRIDE + MAX_SEGMENTS);
         return;
      end
      repeat ($urandom_range(1, 8)) send_item(MODE_EVAL, c, $urandom_range(0, 15), pick_x(c), 1'b1);
   endtask

   task automatic send_noise();
      logic [2:0] mode;
      int c;
      mode = 3'($urandom);
      c = $urandom_range(0, NUM_CURVES - 1);
      if (mode == MODE_EVAL && !sb.curve_ready(c)) mode = MODE_EVAL + 3'($urandom_range(1, 3));
      send_item(mode, c, $urandom_range(0, 15), $urandom, 1'b0);
   endtask

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : receiver
      int gap, pops;
      pops = 0;
      rsp_pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         sb.check_response(rsp_data);
         pops++;
         if (hold_request) begin
            hold_request = 1'b0;
            gap = LONG_HOLD;
         end else begin
            gap = pick_gap(pops);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      int roll;
      bit hold_done, drain_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;
      reset    <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Curve 0: three segments that cover rounding ties both ways and saturation both ways.
      send_item(MODE_LOAD_BP,    0, 0, 32'hFFFF_0000, 1'b1);
      send_item(MODE_LOAD_BP,    0, 1, 32'h0000_0000, 1'b1);
      send_item(MODE_LOAD_BP,    0, 2, 32'h0002_0000, 1'b1);
      send_item(MODE_LOAD_BP,    0, 3, 32'h7FFF_FFFF, 1'b1);
      send_item(MODE_LOAD_SLOPE, 0, 0, 32'h0001_8000, 1'b1);
      send_item(MODE_LOAD_SLOPE, 0, 1, 32'hFFFE_8000, 1'b1);
      send_item(MODE_LOAD_SLOPE, 0, 2, RES_MIN,       1'b1);
      send_item(MODE_LOAD_BASE,  0, 0, 32'h7FFF_0000, 1'b1);
      send_item(MODE_LOAD_BASE,  0, 1, 32'h0000_0000, 1'b1);
      send_item(MODE_LOAD_BASE,  0, 2, RES_MIN,       1'b1);
      send_item(MODE_LOAD_COUNT, 0, 0, 32'd3,         1'b1);
      send_item(MODE_EVAL,       0, 0, RES_MIN,       1'b1);
      send_item(MODE_EVAL,       0, 0, 32'hFFFF_0001, 1'b1);
      send_item(MODE_EVAL,       0, 0, 32'hFFFF_FFFF, 1'b1);
      send_item(MODE_EVAL,       0, 0, 32'h0000_0000, 1'b1);
      send_item(MODE_EVAL,       0, 0, 32'h0000_0001, 1'b1);
      send_item(MODE_EVAL,       0, 0, 32'h0002_0001, 1'b1);
      send_item(MODE_EVAL,       0, 0, RES_MAX,       1'b1);
      // A negative count clamps to zero, so anything at or past the first knot saturates.
      send_item(MODE_LOAD_COUNT, 0, 0, 32'hFFFF_FFFB, 1'b1);
      send_item(MODE_EVAL,       0, 0, 32'h0000_0000, 1'b1);
      send_item(MODE_LOAD_COUNT, 0, 0, 32'd100,       1'b1);
      send_item(MODE_LOAD_COUNT, 0, 0, 32'd3,         1'b1);
      send_item(MODE_LOAD_BP,    0, MAX_SEGMENTS + 1, 32'h1234_5678, 1'b1);
      send_item(MODE_LOAD_SLOPE, 0, MAX_SEGMENTS,     32'h1234_5678, 1'b1);
      send_item(MODE_LOAD_BASE,  0, 15,               32'h1234_5678, 1'b1);
      send_item(MODE_EVAL + 3'd2, 0, 0, 32'hFFFF_FFFF, 1'b1);
      wait_for_results();

      while (useful_items < ITEM_TARGET) begin
         if (!hold_done && useful_items >= 400) begin
            hold_request = 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && useful_items >= 900) begin
            wait_for_results();
            drain_done = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 8)
            send_noise();
         else if (roll < 18)
            load_curve($urandom_range(0, NUM_CURVES - 1), 2 * BP_STRIDE + MAX_SEGMENTS);
         else if (roll < 22)
            load_curve($urandom_range(0, NUM_CURVES - 1), $urandom_range(1, 2 * MAX_SEGMENTS));
         else
            eval_burst();
      end

      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (sb.failures == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
